// ----- src/box_average_downscaler_defines.svh -----
// Assertion macros shared by the box average downscaler modules
`ifndef BOX_AVERAGE_DOWNSCALER_DEFINES_SVH
`define BOX_AVERAGE_DOWNSCALER_DEFINES_SVH

// Same-cycle implication, checked on clk, off while rst_n is low
`define BAV_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low
`define BAV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/bav_pkg.sv -----
// Shared types and constants of the box average downscaler
package bav_pkg;

  // Fixed field widths
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W     = 8;
  localparam int OUT_W     = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_SIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_SIDE = 2'd1;

  // Register reset values
  localparam logic [CFG_W-1:0] SOURCE_SIDE_RST = 10'd224;
  localparam logic [CFG_W-1:0] TARGET_SIDE_RST = 10'd28;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_SETUP,   // start side division after reset or side register write
    ST_CALC,    // wait for block size
    ST_GEOM,    // block area and active region
    ST_IDLE,    // take a pixel request
    ST_ACC,     // accumulate into column sum
    ST_DIV      // wait for block mean and a free output, then load output
  } bav_state_t;

  // Commands from sequencer to datapath
  typedef struct packed {
    logic src_we;
    logic tgt_we;
    logic restart;
    logic accept;
    logic acc;
    logic div_start_cfg;
    logic div_start_avg;
    logic load_b;
    logic load_geom;
    logic load_out;
  } bav_cmd_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic div_busy;
    logic emit;
    logic out_free;
  } bav_sts_t;

endpackage

// ----- src/box_average_downscaler.sv -----
// Top level of the box average downscaler
//
// Usage: source pixels of a square image enter in raster order on the
// in_ channel (valid/ready); floored block means of the target image leave
// on the out_ channel (valid/ready), out_frame_last marking the last one.
// cfg_we/cfg_index/cfg_wdata write source side (index 0) or target side
// (index 1); a write restarts the frame. Write only while the block is idle.
// Each pixel is first accepted; then, inside the active region, its column
// sum in the sum RAM gets a read-add-write. A pixel that closes a block adds
// the mean division: one quotient bit per cycle in the shared divider, then
// the mean is loaded into the output register, raising out_valid. No new
// pixel is taken until this is done. Reset and every side register write
// divide source side by target side and form block area and active region;
// in_ready stays low meanwhile. Column sums need no clearing.
// A stalled receiver holds the result in the output register; pixels keep
// being taken until the next block mean has to be loaded behind it.
module box_average_downscaler #(
  parameter int MAX_SIDE   = 512,
  parameter int PIXEL_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bav_pkg::PIX_W-1:0]     in_pixel,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bav_pkg::OUT_W-1:0]     out_average,
  output logic                          out_frame_last,
  input  logic                          cfg_we,
  input  logic [bav_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bav_pkg::CFG_W-1:0]     cfg_wdata
);

  import bav_pkg::*;

  bav_cmd_t cmd;
  bav_sts_t sts;

  // Sequencer
  bav_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath
  bav_dp #(
    .MAX_SIDE   (MAX_SIDE),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_wdata      (cfg_wdata),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_average    (out_average),
    .out_frame_last (out_frame_last)
  );

endmodule

// ----- src/bav_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module bav_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/bav_div.sv -----
// Restoring divider, one quotient bit per cycle
module bav_div #(
  parameter int DVW = 48,
  parameter int QW  = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [DVW-1:0]           dividend,
  input  logic [DVW-1:0]           divisor,
  input  logic [$clog2(QW+1)-1:0]  nsteps,
  output logic                     busy,
  output logic [QW-1:0]            quotient
);

  localparam int NW = $clog2(QW + 1);

  logic [DVW-1:0] rem_r, rem_nxt;
  logic [DVW-1:0] dsr_r, dsr_nxt;
  logic [QW-1:0]  q_r, q_nxt;
  logic [NW-1:0]  cnt_r, cnt_nxt;
  logic           ge;

  assign busy     = (cnt_r != '0);
  assign quotient = q_r;
  assign ge       = (rem_r >= dsr_r);

  // Load or one compare-subtract step
  always_comb begin
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = dividend;
      dsr_nxt = divisor << (nsteps - NW'(1));
      q_nxt   = '0;
      cnt_nxt = nsteps;
    end else if (busy) begin
      if (ge) begin
        rem_nxt = rem_r - dsr_r;
      end
      dsr_nxt = dsr_r >> 1;
      q_nxt   = {q_r[QW-2:0], ge};
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    q_r   <= q_nxt;
  end

endmodule

// ----- src/bav_dp.sv -----
// Datapath: registers, position counters, column sums, divider, output stage
`include "box_average_downscaler_defines.svh"
module bav_dp #(
  parameter int MAX_SIDE   = 512,
  parameter int PIXEL_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bav_pkg::bav_cmd_t            cmd,
  output bav_pkg::bav_sts_t            sts,
  input  logic [bav_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [bav_pkg::PIX_W-1:0]    in_pixel,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bav_pkg::OUT_W-1:0]    out_average,
  output logic                         out_frame_last
);

  import bav_pkg::*;

  localparam int CW    = $clog2(MAX_SIDE);
  localparam int IW    = $clog2(MAX_SIDE + 1);
  localparam int SW    = (IW > CFG_W) ? IW : CFG_W;
  localparam int PB    = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
  localparam int SUM_W = 2 * IW + PB;
  localparam int DVW   = SUM_W + 2 * SW;
  localparam int NW    = $clog2(SW + 1);

  // Configuration and derived geometry
  logic [CFG_W-1:0]  src_side_r, tgt_side_r;
  logic [SW-1:0]     s_ext, t_ext, s_eff, t_eff, t_m1;
  logic [SW-1:0]     b_r, b_m1, active_r;
  logic [2*SW-1:0]   area_r;

  // Position counters
  logic [CW-1:0]     sc_r, sc_nxt, sr_r, sr_nxt;
  logic [CW-1:0]     cib_r, cib_nxt, rib_r, rib_nxt;
  logic [IW-1:0]     bc_r, bc_nxt, br_r, br_nxt;
  logic [SW-1:0]     sc_inc, sr_inc, cib_inc, rib_inc;
  logic              in_row, in_col, blk_end;

  // Pending pixel
  logic [PB-1:0]     pix_r;
  logic [CW-1:0]     addr_r;
  logic              upd_r, first_r, emit_r, last_r;

  // Sum path and divider
  logic [SUM_W-1:0]  rdata, sum;
  logic [DVW-1:0]    div_dividend, div_divisor;
  logic [NW-1:0]     div_nsteps;
  logic              div_busy;
  logic [SW-1:0]     div_q;

  // Output stage
  logic [OUT_W-1:0]  out_avg_r;
  logic              out_last_r, out_valid_r;

  // Side clamping
  always_comb begin
    s_ext = SW'(src_side_r);
    t_ext = SW'(tgt_side_r);
    if (s_ext == '0) begin
      s_eff = SW'(1);
    end else if (s_ext > SW'(MAX_SIDE)) begin
      s_eff = SW'(MAX_SIDE);
    end else begin
      s_eff = s_ext;
    end
    if (t_ext == '0) begin
      t_eff = SW'(1);
    end else if (t_ext > s_eff) begin
      t_eff = s_eff;
    end else begin
      t_eff = t_ext;
    end
  end

  assign t_m1    = t_eff - SW'(1);
  assign b_m1    = b_r - SW'(1);
  assign in_row  = (SW'(sr_r) < active_r);
  assign in_col  = (SW'(sc_r) < active_r);
  assign blk_end = (SW'(rib_r) == b_m1) && (SW'(cib_r) == b_m1);
  assign sc_inc  = SW'(sc_r) + SW'(1);
  assign sr_inc  = SW'(sr_r) + SW'(1);
  assign cib_inc = SW'(cib_r) + SW'(1);
  assign rib_inc = SW'(rib_r) + SW'(1);

  // Raster position update
  always_comb begin
    sc_nxt  = sc_r;
    sr_nxt  = sr_r;
    cib_nxt = cib_r;
    rib_nxt = rib_r;
    bc_nxt  = bc_r;
    br_nxt  = br_r;
    if (cmd.restart) begin
      sc_nxt  = '0;
      sr_nxt  = '0;
      cib_nxt = '0;
      rib_nxt = '0;
      bc_nxt  = '0;
      br_nxt  = '0;
    end else if (cmd.accept) begin
      if (in_col) begin
        if (cib_inc >= b_r) begin
          cib_nxt = '0;
          bc_nxt  = bc_r + IW'(1);
        end else begin
          cib_nxt = cib_inc[CW-1:0];
        end
      end
      if (sc_inc >= s_eff) begin
        sc_nxt  = '0;
        cib_nxt = '0;
        bc_nxt  = '0;
        if (in_row) begin
          if (rib_inc >= b_r) begin
            rib_nxt = '0;
            br_nxt  = br_r + IW'(1);
          end else begin
            rib_nxt = rib_inc[CW-1:0];
          end
        end
        if (sr_inc >= s_eff) begin
          sr_nxt  = '0;
          rib_nxt = '0;
          br_nxt  = '0;
        end else begin
          sr_nxt = sr_inc[CW-1:0];
        end
      end else begin
        sc_nxt = sc_inc[CW-1:0];
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_side_r  <= SOURCE_SIDE_RST;
      tgt_side_r  <= TARGET_SIDE_RST;
      sc_r        <= '0;
      sr_r        <= '0;
      cib_r       <= '0;
      rib_r       <= '0;
      bc_r        <= '0;
      br_r        <= '0;
      upd_r       <= 1'b0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.src_we) begin
        src_side_r <= cfg_wdata;
      end
      if (cmd.tgt_we) begin
        tgt_side_r <= cfg_wdata;
      end
      sc_r  <= sc_nxt;
      sr_r  <= sr_nxt;
      cib_r <= cib_nxt;
      rib_r <= rib_nxt;
      bc_r  <= bc_nxt;
      br_r  <= br_nxt;
      if (cmd.accept) begin
        upd_r  <= in_row && in_col;
        emit_r <= in_row && in_col && blk_end;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Geometry, pending pixel and output payload
  always_ff @(posedge clk) begin
    if (cmd.load_b) begin
      b_r <= div_q;
    end
    if (cmd.load_geom) begin
      area_r   <= b_r * b_r;
      active_r <= SW'(t_eff * b_r);
    end
    if (cmd.accept) begin
      pix_r   <= in_pixel[PB-1:0];
      addr_r  <= bc_r[CW-1:0];
      first_r <= (rib_r == '0) && (cib_r == '0);
      last_r  <= (SW'(br_r) == t_m1) && (SW'(bc_r) == t_m1);
    end
    if (cmd.load_out) begin
      out_avg_r  <= div_q[OUT_W-1:0];
      out_last_r <= last_r;
    end
  end

  // Column sum: the top-left pixel of a block starts a fresh sum
  assign sum = first_r ? SUM_W'(pix_r) : rdata + SUM_W'(pix_r);

  bav_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_SIDE)
  ) u_sums (
    .clk   (clk),
    .we    (cmd.acc && upd_r),
    .waddr (addr_r),
    .wdata (sum),
    .raddr (bc_r[CW-1:0]),
    .rdata (rdata)
  );

  // Divider operands: side ratio or block mean
  always_comb begin
    if (cmd.div_start_avg) begin
      div_dividend = DVW'(sum);
      div_divisor  = DVW'(area_r);
      div_nsteps   = NW'(PB);
    end else begin
      div_dividend = DVW'(s_eff);
      div_divisor  = DVW'(t_eff);
      div_nsteps   = NW'(SW);
    end
  end

  bav_div #(
    .DVW (DVW),
    .QW  (SW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start_cfg || cmd.div_start_avg),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .nsteps   (div_nsteps),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Status and outputs
  assign sts.div_busy   = div_busy;
  assign sts.emit       = emit_r;
  assign sts.out_free   = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_average    = out_avg_r;
  assign out_frame_last = out_last_r;

  `BAV_ASSERT_SAME(a_no_out_overwrite, cmd.load_out, !out_valid_r || out_ready, "output overwritten while stalled")
  `BAV_ASSERT_SAME(a_emit_needs_update, emit_r, upd_r, "block end flagged outside active region")

endmodule

// ----- src/bav_ctrl.sv -----
// Sequencer: setup after register writes, per-pixel accumulate and divide
`include "box_average_downscaler_defines.svh"
module bav_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              cfg_we,
  input  logic [bav_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  bav_pkg::bav_sts_t                 sts,
  output bav_pkg::bav_cmd_t                 cmd
);

  import bav_pkg::*;

  bav_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SETUP;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.src_we  = cfg_we && (cfg_index == REG_SOURCE_SIDE);
    cmd.tgt_we  = cfg_we && (cfg_index == REG_TARGET_SIDE);
    cmd.restart = cmd.src_we || cmd.tgt_we;
    unique case (state_r)
      ST_SETUP: begin
        cmd.div_start_cfg = 1'b1;
        state_nxt         = ST_CALC;
      end
      ST_CALC: begin
        if (!sts.div_busy) begin
          cmd.load_b = 1'b1;
          state_nxt  = ST_GEOM;
        end
      end
      ST_GEOM: begin
        cmd.load_geom = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready   = !cmd.restart;
        cmd.accept = in_valid && in_ready;
        if (cmd.accept) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        if (sts.emit) begin
          cmd.div_start_avg = 1'b1;
          state_nxt         = ST_DIV;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (!sts.div_busy && sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_SETUP;
      end
    endcase
    // A side register write restarts the frame and recomputes the geometry
    if (cmd.restart) begin
      state_nxt = ST_SETUP;
    end
  end

  `BAV_ASSERT_NEXT(a_accept_to_acc, cmd.accept, state_r == ST_ACC, "accepted pixel not accumulated")
  `BAV_ASSERT_SAME(a_avg_div_free, cmd.div_start_avg, !sts.div_busy, "mean started while divider busy")
  `BAV_ASSERT_SAME(a_ready_only_idle, in_ready, state_r == ST_IDLE, "ready outside idle")

endmodule

// ----- sim/box_average_downscaler_tb.sv -----
// Testbench for the box average downscaler: directed table, then randomized frames
`timescale 1ns / 100ps

module box_average_downscaler_tb;
  import bav_pkg::*;

  localparam int MAX_SIDE       = 512;
  localparam int PIXEL_BITS     = 8;
  localparam int SETTLE_CYCLES  = 30;      // covers a pixel still in the sum RAM
  localparam int RX_HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int PHASE_PIXELS   = 80;
  localparam int DIR_ROWS       = 35;

  // Index that maps to no register; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [OUT_W-1:0] average;
    logic             frame_last;
  } box_mean_t;

  typedef enum {ROW_PIXEL, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     value;
    logic [PIX_W-1:0]     pixel;
    bit                   typed;
    box_mean_t            mean;
  } step_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_pixel;
  logic                 out_valid;
  logic                 out_ready;
  logic [OUT_W-1:0]     out_average;
  logic                 out_frame_last;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  box_average_downscaler #(
    .MAX_SIDE   (MAX_SIDE),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_average    (out_average),
    .out_frame_last (out_frame_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Shadow geometry and frame position
  logic [CFG_W-1:0] reg_source;
  logic [CFG_W-1:0] reg_target;
  logic [25:0]      col_sum [MAX_SIDE];
  int unsigned      src_col, src_row, col_in_blk, row_in_blk, blk_col, blk_row;

  box_mean_t pending_means [$];
  int        mismatches;
  int        cycle_count;
  int        tx_idle_pct;
  int        rx_idle_pct;
  int        rx_hold_req;
  int        rx_hold_seen;
  int        rx_hold_left;

  step_row_t opening_rows [DIR_ROWS];

  function automatic void clear_frame();
    foreach (col_sum[i]) col_sum[i] = '0;
    src_col    = 0;
    src_row    = 0;
    col_in_blk = 0;
    row_in_blk = 0;
    blk_col    = 0;
    blk_row    = 0;
  endfunction

  // Register write: any known index restarts the frame
  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] val);
    if (idx == REG_SOURCE_SIDE) begin
      reg_source = val;
      clear_frame();
    end else if (idx == REG_TARGET_SIDE) begin
      reg_target = val;
      clear_frame();
    end
  endfunction

  // Add one pixel to its block; a block's bottom-right pixel yields its mean
  function automatic void accumulate_pixel(input logic [PIX_W-1:0] pix, output bit got,
                                           output box_mean_t mean);
    int unsigned s, t, b, active;
    bit in_row, in_col;
    s = reg_source;
    if (s < 1) s = 1;
    if (s > MAX_SIDE) s = MAX_SIDE;
    t = reg_target;
    if (t < 1) t = 1;
    if (t > s) t = s;
    b      = s / t;
    active = t * b;
    in_row = src_row < active;
    in_col = src_col < active;
    got    = 1'b0;
    mean   = '0;

    if (in_row && in_col && blk_col < MAX_SIDE) begin
      col_sum[blk_col] = col_sum[blk_col] + 26'(pix);
      if (row_in_blk == b - 1 && col_in_blk == b - 1) begin
        mean.average    = OUT_W'(32'(col_sum[blk_col]) / (b * b));
        mean.frame_last = (blk_row == t - 1) && (blk_col == t - 1);
        col_sum[blk_col] = '0;
        got = 1'b1;
      end
    end

    if (in_col) begin
      col_in_blk++;
      if (col_in_blk >= b) begin
        col_in_blk = 0;
        blk_col++;
      end
    end

    // Step through the raster; wrap column, then row, then frame
    if (src_col + 1 >= s) begin
      src_col    = 0;
      col_in_blk = 0;
      blk_col    = 0;
      if (in_row) begin
        row_in_blk++;
        if (row_in_blk >= b) begin
          row_in_blk = 0;
          blk_row++;
        end
      end
      src_row++;
      if (src_row >= s) begin
        src_row    = 0;
        row_in_blk = 0;
        blk_row    = 0;
      end
    end else begin
      src_col++;
    end
  endfunction

  // Table row builders
  function automatic step_row_t px(input logic [PIX_W-1:0] pix);
    step_row_t r;
    r       = '{kind: ROW_PIXEL, idx: '0, value: '0, pixel: pix, typed: 1'b0, mean: '0};
    return r;
  endfunction

  function automatic step_row_t pxm(input logic [PIX_W-1:0] pix, input logic [OUT_W-1:0] avg,
                                    input logic last);
    step_row_t r;
    r       = px(pix);
    r.typed = 1'b1;
    r.mean  = '{average: avg, frame_last: last};
    return r;
  endfunction

  function automatic step_row_t wr(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    step_row_t r;
    r = '{kind: ROW_WRITE, idx: idx, value: val, pixel: '0, typed: 1'b0, mean: '0};
    return r;
  endfunction

  // Offer one pixel request; queue its mean once accepted
  task automatic offer_pixel(input logic [PIX_W-1:0] pix, input bit typed,
                             input box_mean_t typed_mean);
    bit        got;
    box_mean_t mean;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accumulate_pixel(pix, got, mean);
    if (typed) pending_means.insert(pending_means.size(), typed_mean);
    else if (got) pending_means.insert(pending_means.size(), mean);
  endtask

  // Stop sending and let every queued mean and any pixel in flight drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the enable stays up when another write follows
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val,
                           input bit last);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_write(idx, val);
    if (last) cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] src, input logic [CFG_W-1:0] tgt,
                              input bit target_first);
    wait_idle();
    if (target_first) begin
      reg_write(REG_TARGET_SIDE, tgt, 1'b0);
      reg_write(REG_SOURCE_SIDE, src, 1'b1);
    end else begin
      reg_write(REG_SOURCE_SIDE, src, 1'b0);
      reg_write(REG_TARGET_SIDE, tgt, 1'b1);
    end
  endtask

  // Random geometry, mostly small frames; returns how many pixels to send
  task automatic random_geometry(output int unsigned n_pixels);
    logic [CFG_W-1:0] src, tgt;
    int unsigned      s_eff;
    bit               wide;
    wide = ($urandom_range(99) < 12);
    if (wide) src = CFG_W'($urandom_range(300, 1023));
    else if ($urandom_range(19) == 0) src = '0;
    else src = CFG_W'($urandom_range(1, 9));
    s_eff = (src == 0) ? 1 : (src > MAX_SIDE ? MAX_SIDE : src);
    case ($urandom_range(9))
      0:       tgt = '0;
      1:       tgt = CFG_W'($urandom_range(s_eff, 1023));
      2:       tgt = CFG_W'(s_eff);
      default: tgt = CFG_W'($urandom_range(1, s_eff));
    endcase
    if (wide && $urandom_range(1)) tgt = src;
    set_geometry(src, tgt, 1'($urandom_range(1)));
    // small frames run one whole frame and spill into the next
    if (wide) n_pixels = $urandom_range(20, 60);
    else n_pixels = s_eff * s_eff + $urandom_range(0, 2 * s_eff);
  endtask

  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // Receiver: random stalls, plus a long hold on request
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ready    <= 1'b0;
    end else if (rx_hold_seen != rx_hold_req) begin
      rx_hold_seen <= rx_hold_req;
      rx_hold_left <= RX_HOLD_CYCLES;
      out_ready    <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic void flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Result check against the oldest queued mean
  always @(posedge clk) begin : check_means
    box_mean_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_means.size() == 0) begin
        flag_error($sformatf("unexpected mean: average %0d frame_last %0b",
                             out_average, out_frame_last));
      end else begin
        want = pending_means.pop_front();
        if (out_average !== want.average || out_frame_last !== want.frame_last)
          flag_error($sformatf("mean mismatch: expected average %0d frame_last %0b, got %0d %0b",
                               want.average, want.frame_last, out_average, out_frame_last));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int unsigned n_pixels;
    int unsigned sent;
    bit          last_write;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_pixel     <= '0;
    out_ready    <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_wdata    <= '0;
    mismatches   = 0;
    cycle_count  = 0;
    rx_hold_req  = 0;
    rx_hold_seen = 0;
    rx_hold_left = 0;
    tx_idle_pct  = 35;
    rx_idle_pct  = 73;
    reg_source   = SOURCE_SIDE_RST;
    reg_target   = TARGET_SIDE_RST;
    clear_frame();

    opening_rows = '{
      px(8'hA5),                                          // reset geometry, 8x8 blocks
      wr(REG_SOURCE_SIDE, 10'd1), wr(REG_TARGET_SIDE, 10'd1),
      pxm(8'h00, 8'h00, 1'b1), pxm(8'hFF, 8'hFF, 1'b1), pxm(8'h5A, 8'h5A, 1'b1),
      wr(REG_SOURCE_SIDE, 10'd0),                         // zero source acts as one
      pxm(8'hC3, 8'hC3, 1'b1),
      wr(REG_TARGET_SIDE, 10'd0),                         // zero target acts as one
      pxm(8'h3C, 8'h3C, 1'b1),
      wr(REG_SOURCE_SIDE, 10'd2), wr(REG_TARGET_SIDE, 10'd1),
      px(8'hFF), px(8'hFF), px(8'hFF), pxm(8'hFE, 8'hFE, 1'b1),  // mean floors
      wr(REG_TARGET_SIDE, 10'd5),                         // target clamped to source
      pxm(8'd10, 8'd10, 1'b0), pxm(8'd20, 8'd20, 1'b0),
      pxm(8'd30, 8'd30, 1'b0), pxm(8'd40, 8'd40, 1'b1),
      wr(REG_SOURCE_SIDE, 10'd1023), wr(REG_TARGET_SIDE, 10'd1023),  // both clamp to max
      pxm(8'hFF, 8'hFF, 1'b0), pxm(8'h00, 8'h00, 1'b0),
      wr(REG_SPARE, 10'd1023),                            // no register, no restart
      px(8'h07),
      wr(REG_SOURCE_SIDE, 10'd3), wr(REG_TARGET_SIDE, 10'd2),  // right column dropped
      px(8'd1), px(8'd2), px(8'd3), px(8'd4), px(8'd5), px(8'd6)
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (opening_rows[i].kind == ROW_WRITE) begin
        if (i == 0 || opening_rows[i-1].kind != ROW_WRITE) wait_idle();
        last_write = (i == DIR_ROWS - 1) || (opening_rows[i+1].kind != ROW_WRITE);
        reg_write(opening_rows[i].idx, opening_rows[i].value, last_write);
      end else begin
        offer_pixel(opening_rows[i].pixel, opening_rows[i].typed, opening_rows[i].mean);
      end
    end

    // Random frames under three idle patterns
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin tx_idle_pct = 35; rx_idle_pct = 73; end
        1:       begin tx_idle_pct = 73; rx_idle_pct = 35; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      if (phase == 2) begin
        // one mean per pixel against a stalled receiver backs up the input
        set_geometry(10'd6, 10'd6, 1'b0);
        rx_hold_req <= rx_hold_req + 1;
        for (int k = 0; k < 36; k++) offer_pixel(random_pixel(), 1'b0, '0);
      end
      sent = 0;
      while (sent < PHASE_PIXELS) begin
        random_geometry(n_pixels);
        for (int k = 0; k < n_pixels; k++) offer_pixel(random_pixel(), 1'b0, '0);
        sent += n_pixels;
      end
    end

    // Drain
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
